// ----- rtl/sdspi_pkg.sv -----
// Package for the SD card SPI-mode host sequencer.
// Holds the phase, request, result-kind, register-index, status and command codes,
// the result layout and the command frame byte function. No dependencies.
package sdspi_pkg;

  localparam int unsigned BlockBytes = 512;
  localparam int unsigned CfgW       = 16;
  localparam int unsigned CfgIdxW    = 3;

  typedef enum logic [5:0] {
    PH_IDLE, PH_WOPEN, PH_DUMMY, PH_CMD, PH_RESP, PH_AFTER0, PH_WAIT0, PH_R7,
    PH_AFTER8, PH_AFTER55, PH_AFTER41, PH_WAIT41, PH_TOKEN, PH_RDATA, PH_RCRC,
    PH_RTAIL, PH_ERRTAIL, PH_WGAP, PH_WTOKEN, PH_WDATA, PH_WCRC, PH_WRESP,
    PH_WBUSY, PH_FINTAIL
  } phase_t;

  typedef enum logic [2:0] {
    REQ_CARD_BYTE  = 3'd0,
    REQ_DELAY_DONE = 3'd1,
    REQ_INIT       = 3'd2,
    REQ_READ       = 3'd3,
    REQ_WR_START   = 3'd4,
    REQ_WR_BYTE    = 3'd5,
    REQ_WR_FINISH  = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    KIND_SPI   = 2'd0,
    KIND_RDATA = 2'd1,
    KIND_STAT  = 2'd2,
    KIND_DELAY = 2'd3
  } kind_t;

  localparam logic [CfgIdxW-1:0] REG_RESP_WIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RST_TRIES = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RDY_TRIES = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TOKEN_TO  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BUSY_TO   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ERR     = 2'd1;
  localparam logic [1:0] ST_NO_INIT = 2'd2;

  localparam logic [5:0] CMD_GO_IDLE = 6'd0;
  localparam logic [5:0] CMD_IF_COND = 6'd8;
  localparam logic [5:0] CMD_RD_BLK  = 6'd17;
  localparam logic [5:0] CMD_WR_BLK  = 6'd24;
  localparam logic [5:0] CMD_APP     = 6'd55;
  localparam logic [5:0] CMD_OP_COND = 6'd41;

  typedef struct packed {
    logic        last;
    logic [1:0]  kind;
    logic        fast;
    logic [3:0]  dly;
    logic [1:0]  st;
    logic [7:0]  rd;
    logic        cs;
    logic [7:0]  tx;
  } res_t;

  function automatic res_t make_res(logic [1:0] kind, logic [7:0] tx, logic cs,
                                    logic [7:0] rd, logic [1:0] st, logic [3:0] dly,
                                    logic fast);
    res_t r;
    r.last = 1'b0;
    r.kind = kind;
    r.fast = fast;
    r.dly  = dly;
    r.st   = st;
    r.rd   = rd;
    r.cs   = cs;
    r.tx   = tx;
    return r;
  endfunction

  // byte i of a command frame; index 6 is the fixed CRC
  function automatic logic [7:0] frame_byte(logic [2:0] i, logic [5:0] cmd, logic [31:0] arg);
    logic [7:0] b;
    case (i)
      3'd1:    b = {2'b01, cmd};
      3'd2:    b = arg[31:24];
      3'd3:    b = arg[23:16];
      3'd4:    b = arg[15:8];
      3'd5:    b = arg[7:0];
      default: b = (cmd == CMD_IF_COND) ? 8'h87 : 8'h95;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/sd_card_spi_host_sequencer_unit.sv -----
// SD card SPI-mode host sequencer, top level.
// Latency: results enter a 4-deep result queue at the accept edge and can leave it from the next cycle.
// Throughput: one request per cycle while at most two queue entries are occupied.
// Each request yields up to two results, drained one per cycle while out_tready is high.
// Reset (rst_n low, synchronous): phase idle, counters clear, registers to defaults.
// Uses sdspi_pkg.
module sd_card_spi_host_sequencer_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // card_byte[7:0], sector[39:8], offset[48:40], count[58:49], data_byte[66:59], zero pad
  input  logic [71:0]                        in_tdata,
  // command
  input  logic [2:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tx_byte[7:0], chip_select[8], read_byte[16:9], status[18:17], delay_ms[22:19],
  // fast_clock[23]
  output logic [23:0]                        out_tdata,
  // kind
  output logic [1:0]                         out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_wen,
  input  logic [sdspi_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [sdspi_pkg::CfgW-1:0]         cfg_data
);
  import sdspi_pkg::*;

  logic [7:0]  resp_win_r, rst_tries_r;
  logic [15:0] rdy_tries_r, token_to_r, busy_to_r;

  phase_t      phase_r, phase_nxt;
  logic [9:0]  byte_cnt_r, byte_cnt_nxt;
  logic [15:0] retry_r, retry_nxt, poll_r, poll_nxt;
  logic [2:0]  frame_r, frame_nxt;
  logic [5:0]  cur_cmd_r, cur_cmd_nxt;
  logic [31:0] arg_r, arg_nxt;
  logic [8:0]  win_start_r, win_start_nxt;
  logic [9:0]  win_len_r, win_len_nxt;
  logic [7:0]  last_resp_r, last_resp_nxt;
  logic        fast_r, fast_nxt;

  res_t        q_r [4];
  logic [1:0]  wptr_r, rptr_r;
  logic [2:0]  cnt_r;

  logic        acc, pop;
  res_t        res0, res1;
  logic [1:0]  nres;

  logic [7:0]  cb, db;
  logic [31:0] sec;
  logic [2:0]  cmd;
  logic        beg;
  logic [5:0]  beg_cmd;
  logic [31:0] beg_arg;
  logic        fin;
  logic [1:0]  fin_st;
  logic        emit_en;
  res_t        emit_v;
  logic [10:0] win_end;
  logic [15:0] poll_inc, retry_inc;
  logic [9:0]  bc_inc;
  logic [2:0]  fr_inc;
  logic        req_ready;

  assign cb  = in_tdata[7:0];
  assign sec = in_tdata[39:8];
  assign db  = in_tdata[66:59];
  assign cmd = in_tuser;

  assign in_tready = (cnt_r <= 3'd2);
  assign acc       = in_tvalid && in_tready;
  assign pop       = out_tvalid && out_tready;

  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = {q_r[rptr_r].fast, q_r[rptr_r].dly, q_r[rptr_r].st, q_r[rptr_r].rd,
                       q_r[rptr_r].cs, q_r[rptr_r].tx};
  assign out_tuser  = q_r[rptr_r].kind;
  assign out_tlast  = q_r[rptr_r].last;

  assign win_end   = {2'b00, win_start_r} + {1'b0, win_len_r};
  assign poll_inc  = poll_r + 16'd1;
  assign retry_inc = retry_r + 16'd1;
  assign bc_inc    = byte_cnt_r + 10'd1;
  assign fr_inc    = frame_r + 3'd1;
  assign req_ready = (phase_r == PH_IDLE) || (phase_r == PH_WOPEN);

  // first pass: state update and the one control-path result (emit_v)
  always_comb begin
    phase_nxt     = phase_r;
    byte_cnt_nxt  = byte_cnt_r;
    retry_nxt     = retry_r;
    poll_nxt      = poll_r;
    frame_nxt     = frame_r;
    cur_cmd_nxt   = cur_cmd_r;
    arg_nxt       = arg_r;
    win_start_nxt = win_start_r;
    win_len_nxt   = win_len_r;
    last_resp_nxt = last_resp_r;
    fast_nxt      = fast_r;
    beg     = 1'b0;
    beg_cmd = CMD_GO_IDLE;
    beg_arg = 32'd0;
    fin     = 1'b0;
    fin_st  = ST_OK;
    emit_en = 1'b0;
    emit_v  = make_res(KIND_SPI, 8'hFF, 1'b0, 8'd0, ST_OK, 4'd0, 1'b0);
    res0    = emit_v;
    nres    = 2'd0;

    if (cmd == REQ_CARD_BYTE) begin
      case (phase_r)
        PH_DUMMY: begin
          byte_cnt_nxt = bc_inc;
          if (bc_inc < 10'd10) begin
            emit_en = 1'b1; emit_v.cs = 1'b1;
          end else begin
            retry_nxt = 16'd0; beg = 1'b1; beg_cmd = CMD_GO_IDLE;
          end
        end
        PH_CMD: begin
          frame_nxt = fr_inc;
          emit_en   = 1'b1;
          if (fr_inc < 3'd7) begin
            emit_v.tx = frame_byte(fr_inc, cur_cmd_r, arg_r);
          end else begin
            poll_nxt = 16'd0; phase_nxt = PH_RESP;
          end
        end
        PH_RESP: begin
          poll_nxt = poll_inc;
          emit_en  = 1'b1;
          if (cb != 8'hFF || poll_inc >= {8'd0, resp_win_r}) begin
            last_resp_nxt = cb;
            case (cur_cmd_r)
              CMD_GO_IDLE: begin phase_nxt = PH_AFTER0; emit_v.cs = 1'b1; end
              CMD_IF_COND: begin byte_cnt_nxt = 10'd0; phase_nxt = PH_R7; end
              CMD_APP:     begin phase_nxt = PH_AFTER55; emit_v.cs = 1'b1; end
              CMD_OP_COND: begin phase_nxt = PH_AFTER41; emit_v.cs = 1'b1; end
              CMD_RD_BLK: begin
                if (cb != 8'd0) begin
                  phase_nxt = PH_ERRTAIL; emit_v.cs = 1'b1;
                end else begin
                  poll_nxt = 16'd0; phase_nxt = PH_TOKEN;
                end
              end
              default: begin
                if (cb != 8'd0) begin
                  phase_nxt = PH_ERRTAIL; emit_v.cs = 1'b1;
                end else begin
                  phase_nxt = PH_WGAP;
                end
              end
            endcase
          end
        end
        PH_AFTER0: begin
          phase_nxt = PH_WAIT0; emit_en = 1'b1;
          emit_v = make_res(KIND_DELAY, 8'd0, 1'b0, 8'd0, ST_OK, 4'd10, 1'b0);
        end
        PH_R7: begin
          byte_cnt_nxt = bc_inc; emit_en = 1'b1;
          if (bc_inc >= 10'd4) begin
            phase_nxt = PH_AFTER8; emit_v.cs = 1'b1;
          end
        end
        PH_AFTER8: begin
          retry_nxt = 16'd0; beg = 1'b1; beg_cmd = CMD_APP;
        end
        PH_AFTER55: begin
          beg = 1'b1; beg_cmd = CMD_OP_COND; beg_arg = 32'h4000_0000;
        end
        PH_AFTER41: begin
          phase_nxt = PH_WAIT41; emit_en = 1'b1;
          emit_v = make_res(KIND_DELAY, 8'd0, 1'b0, 8'd0, ST_OK, 4'd1, 1'b0);
        end
        PH_TOKEN: begin
          poll_nxt = poll_inc; emit_en = 1'b1;
          if (cb == 8'hFE) begin
            byte_cnt_nxt = 10'd0; phase_nxt = PH_RDATA;
          end else if (poll_inc >= token_to_r) begin
            phase_nxt = PH_ERRTAIL; emit_v.cs = 1'b1;
          end
        end
        PH_RDATA: begin
          emit_en = 1'b1;
          byte_cnt_nxt = bc_inc;
          if (bc_inc >= 10'(BlockBytes)) begin
            byte_cnt_nxt = 10'd0; phase_nxt = PH_RCRC;
          end
        end
        PH_RCRC: begin
          byte_cnt_nxt = bc_inc; emit_en = 1'b1;
          if (bc_inc >= 10'd2) begin
            phase_nxt = PH_RTAIL; emit_v.cs = 1'b1;
          end
        end
        PH_RTAIL:   begin fin = 1'b1; fin_st = ST_OK; end
        PH_ERRTAIL: begin fin = 1'b1; fin_st = ST_ERR; end
        PH_FINTAIL: begin fin = 1'b1; fin_st = ST_OK; end
        PH_WGAP: begin
          phase_nxt = PH_WTOKEN; emit_en = 1'b1; emit_v.tx = 8'hFE;
        end
        PH_WTOKEN: begin
          byte_cnt_nxt = 10'd0; phase_nxt = PH_WOPEN; emit_en = 1'b1;
          emit_v = make_res(KIND_STAT, 8'd0, 1'b0, 8'd0, ST_OK, 4'd0, 1'b0);
        end
        PH_WDATA: begin
          byte_cnt_nxt = bc_inc; emit_en = 1'b1;
          if (bc_inc < 10'(BlockBytes)) begin
            phase_nxt = PH_WOPEN;
            emit_v = make_res(KIND_STAT, 8'd0, 1'b0, 8'd0, ST_OK, 4'd0, 1'b0);
          end else begin
            byte_cnt_nxt = 10'd0; phase_nxt = PH_WCRC;
          end
        end
        PH_WCRC: begin
          byte_cnt_nxt = bc_inc; emit_en = 1'b1;
          if (bc_inc >= 10'd2) phase_nxt = PH_WRESP;
        end
        PH_WRESP: begin
          emit_en = 1'b1;
          if (cb[4:0] != 5'h05) begin
            phase_nxt = PH_ERRTAIL; emit_v.cs = 1'b1;
          end else begin
            poll_nxt = 16'd0; phase_nxt = PH_WBUSY;
          end
        end
        PH_WBUSY: begin
          if (cb != 8'd0) begin
            fin = 1'b1; fin_st = ST_OK;
          end else begin
            poll_nxt = poll_inc;
            if (poll_inc >= busy_to_r) begin
              fin = 1'b1; fin_st = ST_ERR;
            end else begin
              emit_en = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end else if (cmd == REQ_DELAY_DONE) begin
      if (phase_r == PH_WAIT0) begin
        if (last_resp_r == 8'h01) begin
          beg = 1'b1; beg_cmd = CMD_IF_COND; beg_arg = 32'h0000_01AA;
        end else begin
          retry_nxt = retry_inc;
          if (retry_inc >= {8'd0, rst_tries_r}) begin
            fin = 1'b1; fin_st = ST_NO_INIT;
          end else begin
            beg = 1'b1; beg_cmd = CMD_GO_IDLE;
          end
        end
      end else if (phase_r == PH_WAIT41) begin
        if (last_resp_r == 8'h00) begin
          fast_nxt = 1'b1; fin = 1'b1; fin_st = ST_OK;
        end else begin
          retry_nxt = retry_inc;
          if (retry_inc >= rdy_tries_r) begin
            fin = 1'b1; fin_st = ST_NO_INIT;
          end else begin
            beg = 1'b1; beg_cmd = CMD_APP;
          end
        end
      end
    end else if (cmd != 3'd7 && !req_ready) begin
      emit_en = 1'b1;
      emit_v  = make_res(KIND_STAT, 8'd0, 1'b0, 8'd0, ST_ERR, 4'd0, 1'b0);
    end else begin
      case (cmd)
        REQ_INIT: begin
          fast_nxt = 1'b0; byte_cnt_nxt = 10'd0; phase_nxt = PH_DUMMY;
          emit_en = 1'b1; emit_v.cs = 1'b1;
        end
        REQ_READ: begin
          win_start_nxt = in_tdata[48:40];
          win_len_nxt   = in_tdata[58:49];
          beg = 1'b1; beg_cmd = CMD_RD_BLK; beg_arg = sec;
        end
        REQ_WR_START: begin
          beg = 1'b1; beg_cmd = CMD_WR_BLK; beg_arg = sec;
        end
        REQ_WR_BYTE: begin
          emit_en = 1'b1;
          if (phase_r == PH_WOPEN) begin
            phase_nxt = PH_WDATA; emit_v.tx = db;
          end else begin
            emit_v = make_res(KIND_STAT, 8'd0, 1'b0, 8'd0, ST_ERR, 4'd0, 1'b0);
          end
        end
        REQ_WR_FINISH: begin
          phase_nxt = PH_FINTAIL; emit_en = 1'b1; emit_v.cs = 1'b1;
        end
        default: ;
      endcase
    end

    if (beg) begin
      cur_cmd_nxt = beg_cmd; arg_nxt = beg_arg; frame_nxt = 3'd0; phase_nxt = PH_CMD;
      emit_en = 1'b1;
      emit_v  = make_res(KIND_SPI, 8'hFF, 1'b0, 8'd0, ST_OK, 4'd0, 1'b0);
    end
    if (fin) begin
      phase_nxt = PH_IDLE; emit_en = 1'b1;
      emit_v = make_res(KIND_STAT, 8'd0, 1'b0, 8'd0, fin_st, 4'd0, 1'b0);
    end
    emit_v.fast = fast_nxt;

    // read data inside the window goes out ahead of the poll byte
    if (cmd == REQ_CARD_BYTE && phase_r == PH_RDATA &&
        byte_cnt_r >= {1'b0, win_start_r} && {1'b0, byte_cnt_r} < win_end) begin
      res0 = make_res(KIND_RDATA, 8'd0, 1'b0, cb, ST_OK, 4'd0, fast_nxt);
      res1 = emit_v;
      res1.last = 1'b1;
      nres = 2'd2;
    end else begin
      res0 = emit_v;
      res0.last = 1'b1;
      res1 = emit_v;
      nres = emit_en ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_win_r  <= 8'd10;
      rst_tries_r <= 8'd10;
      rdy_tries_r <= 16'd2000;
      token_to_r  <= 16'd10000;
      busy_to_r   <= 16'd10000;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_RESP_WIN:  resp_win_r  <= cfg_data[7:0];
        REG_RST_TRIES: rst_tries_r <= cfg_data[7:0];
        REG_RDY_TRIES: rdy_tries_r <= cfg_data;
        REG_TOKEN_TO:  token_to_r  <= cfg_data;
        REG_BUSY_TO:   busy_to_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      byte_cnt_r  <= 10'd0;
      retry_r     <= 16'd0;
      poll_r      <= 16'd0;
      frame_r     <= 3'd0;
      cur_cmd_r   <= 6'd0;
      arg_r       <= 32'd0;
      win_start_r <= 9'd0;
      win_len_r   <= 10'd0;
      last_resp_r <= 8'hFF;
      fast_r      <= 1'b0;
    end else if (acc) begin
      phase_r     <= phase_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      retry_r     <= retry_nxt;
      poll_r      <= poll_nxt;
      frame_r     <= frame_nxt;
      cur_cmd_r   <= cur_cmd_nxt;
      arg_r       <= arg_nxt;
      win_start_r <= win_start_nxt;
      win_len_r   <= win_len_nxt;
      last_resp_r <= last_resp_nxt;
      fast_r      <= fast_nxt;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (acc && nres != 2'd0) q_r[wptr_r] <= res0;
    if (acc && nres == 2'd2) q_r[wptr_r + 2'd1] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 2'd0;
      rptr_r <= 2'd0;
      cnt_r  <= 3'd0;
    end else begin
      wptr_r <= wptr_r + (acc ? nres : 2'd0);
      rptr_r <= rptr_r + {1'b0, pop};
      cnt_r  <= cnt_r + {1'b0, (acc ? nres : 2'd0)} - {2'b00, pop};
    end
  end

endmodule

// ----- tb/sv/sd_card_spi_host_sequencer_unit_tb.sv -----
// Self-checking testbench for the SD card SPI-mode host sequencer.
// Card-side traffic is planned against a behavioral copy of the sequencer; a second copy
// predicts the results of each accepted transfer. Depends on sdspi_pkg and the top level.
module sd_card_spi_host_sequencer_unit_tb;
  import sdspi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct {
    logic [2:0]  cmd;
    logic [7:0]  cbyte;
    logic [31:0] sector;
    logic [8:0]  offset;
    logic [9:0]  count;
    logic [7:0]  dbyte;
  } sd_req_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] tx;
    logic       cs;
    logic [7:0] rd;
    logic [1:0] st;
    logic [3:0] dly;
    logic       fast;
    logic       last;
  } sd_res_t;

  typedef struct {
    phase_t      ph;
    int unsigned bcnt, retry, poll, frame, wstart, wlen;
    logic [5:0]  cmd;
    logic [31:0] arg;
    logic [7:0]  lastr;
    logic        fast;
    logic [7:0]  resp_win, rst_tries;
    logic [15:0] rdy_tries, tok_to, busy_to;
  } seq_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_wen = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;

  sd_card_spi_host_sequencer_unit DUT (.*);

  always #6 clk = ~clk;

  // working copy used by the sequencer functions below
  seq_state_t sq;
  sd_res_t    rs[3];
  int         rn;

  seq_state_t plan_st, pred_st;
  sd_req_t    pending[$];
  sd_res_t    expected[$];
  int         fails = 0;
  int         phase_items;
  bit         dead_card = 0;

  function automatic seq_state_t reset_state();
    seq_state_t s;
    s.ph = PH_IDLE; s.bcnt = 0; s.retry = 0; s.poll = 0; s.frame = 0;
    s.wstart = 0; s.wlen = 0; s.cmd = '0; s.arg = '0; s.lastr = 8'hFF; s.fast = 1'b0;
    s.resp_win = 8'd10; s.rst_tries = 8'd10; s.rdy_tries = 16'd2000;
    s.tok_to = 16'd10000; s.busy_to = 16'd10000;
    return s;
  endfunction

  function automatic void set_reg(inout seq_state_t s, input logic [CfgIdxW-1:0] idx,
                                  input logic [15:0] val);
    case (idx)
      REG_RESP_WIN:  s.resp_win = val[7:0];
      REG_RST_TRIES: s.rst_tries = val[7:0];
      REG_RDY_TRIES: s.rdy_tries = val;
      REG_TOKEN_TO:  s.tok_to = val;
      REG_BUSY_TO:   s.busy_to = val;
      default: ;
    endcase
  endfunction

  function automatic void emit(kind_t k, logic [7:0] tx, logic cs, logic [7:0] rd,
                               logic [1:0] stv, logic [3:0] dly);
    if (rn < 3) begin
      rs[rn] = '{kind: k, tx: tx, cs: cs, rd: rd, st: stv, dly: dly, fast: sq.fast, last: 1'b0};
      rn++;
    end
  endfunction

  function automatic void send(logic [7:0] tx, logic cs);
    emit(KIND_SPI, tx, cs, 8'h00, 2'd0, 4'd0);
  endfunction

  function automatic void done(logic [1:0] stv);
    sq.ph = PH_IDLE;
    emit(KIND_STAT, 8'h00, 1'b0, 8'h00, stv, 4'd0);
  endfunction

  function automatic void start_frame(logic [5:0] c, logic [31:0] a);
    sq.cmd = c; sq.arg = a; sq.frame = 0; sq.ph = PH_CMD;
    send(8'hFF, 1'b0);
  endfunction

  function automatic logic [7:0] cmd_frame_byte(int unsigned i);
    case (i)
      1: return {2'b01, sq.cmd};
      2: return sq.arg[31:24];
      3: return sq.arg[23:16];
      4: return sq.arg[15:8];
      5: return sq.arg[7:0];
      default: return (sq.cmd == CMD_IF_COND) ? 8'h87 : 8'h95;
    endcase
  endfunction

  function automatic void take_r1(logic [7:0] r);
    sq.lastr = r;
    case (sq.cmd)
      CMD_GO_IDLE: begin sq.ph = PH_AFTER0; send(8'hFF, 1'b1); end
      CMD_IF_COND: begin sq.bcnt = 0; sq.ph = PH_R7; send(8'hFF, 1'b0); end
      CMD_APP:     begin sq.ph = PH_AFTER55; send(8'hFF, 1'b1); end
      CMD_OP_COND: begin sq.ph = PH_AFTER41; send(8'hFF, 1'b1); end
      CMD_RD_BLK: begin
        if (r != 8'h00) begin sq.ph = PH_ERRTAIL; send(8'hFF, 1'b1); end
        else begin sq.poll = 0; sq.ph = PH_TOKEN; send(8'hFF, 1'b0); end
      end
      default: begin
        if (r != 8'h00) begin sq.ph = PH_ERRTAIL; send(8'hFF, 1'b1); end
        else begin sq.ph = PH_WGAP; send(8'hFF, 1'b0); end
      end
    endcase
  endfunction

  function automatic void card_byte_in(logic [7:0] b);
    case (sq.ph)
      PH_DUMMY: begin
        sq.bcnt++;
        if (sq.bcnt < 10) send(8'hFF, 1'b1);
        else begin sq.retry = 0; start_frame(CMD_GO_IDLE, 32'h0); end
      end
      PH_CMD: begin
        sq.frame++;
        if (sq.frame < 7) send(cmd_frame_byte(sq.frame), 1'b0);
        else begin sq.poll = 0; sq.ph = PH_RESP; send(8'hFF, 1'b0); end
      end
      PH_RESP: begin
        sq.poll++;
        if (b != 8'hFF || sq.poll >= sq.resp_win) take_r1(b);
        else send(8'hFF, 1'b0);
      end
      PH_AFTER0: begin sq.ph = PH_WAIT0; emit(KIND_DELAY, 8'h00, 1'b0, 8'h00, 2'd0, 4'd10); end
      PH_R7: begin
        sq.bcnt++;
        if (sq.bcnt < 4) send(8'hFF, 1'b0);
        else begin sq.ph = PH_AFTER8; send(8'hFF, 1'b1); end
      end
      PH_AFTER8:  begin sq.retry = 0; start_frame(CMD_APP, 32'h0); end
      PH_AFTER55: start_frame(CMD_OP_COND, 32'h4000_0000);
      PH_AFTER41: begin sq.ph = PH_WAIT41; emit(KIND_DELAY, 8'h00, 1'b0, 8'h00, 2'd0, 4'd1); end
      PH_TOKEN: begin
        sq.poll++;
        if (b == 8'hFE) begin sq.bcnt = 0; sq.ph = PH_RDATA; send(8'hFF, 1'b0); end
        else if (sq.poll >= sq.tok_to) begin sq.ph = PH_ERRTAIL; send(8'hFF, 1'b1); end
        else send(8'hFF, 1'b0);
      end
      PH_RDATA: begin
        if (sq.bcnt >= sq.wstart && sq.bcnt < sq.wstart + sq.wlen)
          emit(KIND_RDATA, 8'h00, 1'b0, b, 2'd0, 4'd0);
        sq.bcnt++;
        if (sq.bcnt >= BlockBytes) begin sq.bcnt = 0; sq.ph = PH_RCRC; end
        send(8'hFF, 1'b0);
      end
      PH_RCRC: begin
        sq.bcnt++;
        if (sq.bcnt < 2) send(8'hFF, 1'b0);
        else begin sq.ph = PH_RTAIL; send(8'hFF, 1'b1); end
      end
      PH_RTAIL:   done(ST_OK);
      PH_ERRTAIL: done(ST_ERR);
      PH_WGAP:    begin sq.ph = PH_WTOKEN; send(8'hFE, 1'b0); end
      PH_WTOKEN: begin
        sq.bcnt = 0; sq.ph = PH_WOPEN;
        emit(KIND_STAT, 8'h00, 1'b0, 8'h00, ST_OK, 4'd0);
      end
      PH_WDATA: begin
        sq.bcnt++;
        if (sq.bcnt < BlockBytes) begin
          sq.ph = PH_WOPEN;
          emit(KIND_STAT, 8'h00, 1'b0, 8'h00, ST_OK, 4'd0);
        end else begin
          sq.bcnt = 0; sq.ph = PH_WCRC; send(8'hFF, 1'b0);
        end
      end
      PH_WCRC: begin
        sq.bcnt++;
        if (sq.bcnt >= 2) sq.ph = PH_WRESP;
        send(8'hFF, 1'b0);
      end
      PH_WRESP: begin
        if (b[4:0] != 5'h05) begin sq.ph = PH_ERRTAIL; send(8'hFF, 1'b1); end
        else begin sq.poll = 0; sq.ph = PH_WBUSY; send(8'hFF, 1'b0); end
      end
      PH_WBUSY: begin
        if (b != 8'h00) done(ST_OK);
        else begin
          sq.poll++;
          if (sq.poll >= sq.busy_to) done(ST_ERR);
          else send(8'hFF, 1'b0);
        end
      end
      PH_FINTAIL: done(ST_OK);
      default: ;
    endcase
  endfunction

  function automatic void delay_done_in();
    if (sq.ph == PH_WAIT0) begin
      if (sq.lastr == 8'h01) start_frame(CMD_IF_COND, 32'h1AA);
      else begin
        sq.retry++;
        if (sq.retry >= sq.rst_tries) done(ST_NO_INIT);
        else start_frame(CMD_GO_IDLE, 32'h0);
      end
    end else if (sq.ph == PH_WAIT41) begin
      if (sq.lastr == 8'h00) begin sq.fast = 1'b1; done(ST_OK); end
      else begin
        sq.retry++;
        if (sq.retry >= sq.rdy_tries) done(ST_NO_INIT);
        else start_frame(CMD_APP, 32'h0);
      end
    end
  endfunction

  function automatic void seq_step(sd_req_t r);
    logic ready;
    rn = 0;
    ready = (sq.ph == PH_IDLE || sq.ph == PH_WOPEN);
    if (r.cmd == REQ_CARD_BYTE) card_byte_in(r.cbyte);
    else if (r.cmd == REQ_DELAY_DONE) delay_done_in();
    else if (r.cmd != REQ_UNUSED && !ready) emit(KIND_STAT, 8'h00, 1'b0, 8'h00, ST_ERR, 4'd0);
    else if (r.cmd == REQ_INIT) begin
      sq.fast = 1'b0; sq.bcnt = 0; sq.ph = PH_DUMMY; send(8'hFF, 1'b1);
    end else if (r.cmd == REQ_READ) begin
      sq.wstart = r.offset; sq.wlen = r.count;
      start_frame(CMD_RD_BLK, r.sector);
    end else if (r.cmd == REQ_WR_START) start_frame(CMD_WR_BLK, r.sector);
    else if (r.cmd == REQ_WR_BYTE) begin
      if (sq.ph == PH_WOPEN) begin sq.ph = PH_WDATA; send(r.dbyte, 1'b0); end
      else emit(KIND_STAT, 8'h00, 1'b0, 8'h00, ST_ERR, 4'd0);
    end else if (r.cmd == REQ_WR_FINISH) begin
      sq.ph = PH_FINTAIL; send(8'hFF, 1'b1);
    end
    if (rn > 0) rs[rn-1].last = 1'b1;
  endfunction

  // ---------------- stimulus planning ----------------
  function automatic sd_req_t rand_req(logic [2:0] c);
    sd_req_t r;
    r.cmd = c; r.cbyte = 8'($urandom); r.sector = $urandom;
    r.offset = 9'($urandom); r.count = 10'($urandom); r.dbyte = 8'($urandom);
    return r;
  endfunction

  task automatic queue_req(sd_req_t r);
    sq = plan_st;
    seq_step(r);
    plan_st = sq;
    pending.push_back(r);
    phase_items++;
  endtask

  function automatic logic [7:0] card_reply();
    logic [7:0] rnd;
    rnd = 8'($urandom);
    case (plan_st.ph)
      PH_RESP: begin
        if ($urandom_range(0, 3) == 0) return 8'hFF;
        case (plan_st.cmd)
          CMD_GO_IDLE: return dead_card ? 8'h00 : ($urandom_range(0, 7) == 0 ? rnd : 8'h01);
          CMD_APP:     return 8'h01;
          CMD_OP_COND: return ($urandom_range(0, 2) == 0) ? 8'h00 : 8'h01;
          CMD_IF_COND: return rnd;
          default:     return ($urandom_range(0, 5) == 0) ? rnd : 8'h00;
        endcase
      end
      PH_TOKEN: begin
        // no start token: reads stay short and end on the token timeout
        return ($urandom_range(0, 1) == 0 || rnd == 8'hFE) ? 8'hFF : rnd;
      end
      PH_WRESP: return ($urandom_range(0, 4) == 0) ? rnd : {rnd[7:5], 5'h05};
      PH_WBUSY: return ($urandom_range(0, 2) == 0) ? rnd : 8'h00;
      default:  return rnd;
    endcase
  endfunction

  // play the card until the sequencer is back to idle or has a write block open
  task automatic play_card();
    sd_req_t r;
    while (plan_st.ph != PH_IDLE && plan_st.ph != PH_WOPEN) begin
      if ($urandom_range(0, 39) == 0) begin
        // noise: a request while busy, an unused code or an event nobody waits for
        r = rand_req(3'($urandom_range(2, 7)));
        if ($urandom_range(0, 2) == 0)
          r.cmd = (plan_st.ph == PH_WAIT0 || plan_st.ph == PH_WAIT41) ?
                  REQ_CARD_BYTE : REQ_DELAY_DONE;
        queue_req(r);
      end
      if (plan_st.ph == PH_WAIT0 || plan_st.ph == PH_WAIT41) r = rand_req(REQ_DELAY_DONE);
      else begin
        r = rand_req(REQ_CARD_BYTE);
        r.cbyte = card_reply();
      end
      queue_req(r);
    end
  endtask

  task automatic do_request(sd_req_t r);
    queue_req(r);
    play_card();
  endtask

  task automatic do_read(logic [31:0] sector, logic [8:0] off, logic [9:0] cnt);
    sd_req_t r;
    r = rand_req(REQ_READ);
    r.sector = sector; r.offset = off; r.count = cnt;
    do_request(r);
  endtask

  task automatic do_write(int nbytes, bit close);
    do_request(rand_req(REQ_WR_START));
    for (int i = 0; i < nbytes && plan_st.ph == PH_WOPEN; i++)
      do_request(rand_req(REQ_WR_BYTE));
    if (close && plan_st.ph == PH_WOPEN) do_request(rand_req(REQ_WR_FINISH));
  endtask

  task automatic random_traffic(int target);
    int pick;
    phase_items = 0;
    while (phase_items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        dead_card = ($urandom_range(0, 5) == 0);
        do_request(rand_req(REQ_INIT));
        dead_card = 0;
      end else if (pick < 25) begin
        case ($urandom_range(0, 3))
          0: do_read($urandom, 9'($urandom), 10'd0);
          1: do_read($urandom, 9'($urandom), 10'($urandom_range(1, 16)));
          2: do_read($urandom, 9'($urandom), 10'd512);
          default: do_read($urandom, 9'($urandom), 10'($urandom));
        endcase
      end else if (pick < 75) begin
        do_write($urandom_range(0, 6), $urandom_range(0, 3) != 0);
      end else if (pick < 85) begin
        do_request(rand_req(3'($urandom_range(REQ_WR_BYTE, REQ_WR_FINISH))));
      end else begin
        queue_req(rand_req(3'($urandom_range(0, 1)) == 0 ? REQ_CARD_BYTE :
                           ($urandom_range(0, 1) == 0 ? REQ_DELAY_DONE : REQ_UNUSED)));
      end
    end
  endtask

  task automatic wait_quiet();
    while (pending.size() != 0 || in_tvalid || expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    set_reg(pred_st, idx, val);
    set_reg(plan_st, idx, val);
  endtask

  task automatic set_limits(logic [7:0] win, logic [7:0] rst, logic [15:0] rdy,
                            logic [15:0] tok, logic [15:0] busy);
    wait_quiet();
    reg_write(REG_RESP_WIN, {8'h00, win});
    reg_write(REG_RST_TRIES, {8'h00, rst});
    reg_write(REG_RDY_TRIES, rdy);
    reg_write(REG_TOKEN_TO, tok);
    reg_write(REG_BUSY_TO, busy);
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // ---------------- driver ----------------
  sd_req_t drv_cur;
  int      drv_gap = 0;
  bit      drv_quiet = 0;
  int      activity = 0;

  always @(posedge clk) begin : driver
    logic nv;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nv = in_tvalid;
      if ($urandom_range(0, 399) == 0) drv_quiet = !drv_quiet;
      if (in_tvalid && in_tready) begin
        sq = pred_st;
        seq_step(drv_cur);
        pred_st = sq;
        for (int i = 0; i < rn; i++) expected.push_back(rs[i]);
        nv = 1'b0;
        activity++;
      end
      if (!nv) begin
        if (drv_gap > 0) drv_gap--;
        else if (pending.size() != 0) begin
          drv_cur = pending.pop_front();
          nv = 1'b1;
          drv_gap = pick_gap(drv_quiet);
          in_tdata <= {5'd0, drv_cur.dbyte, drv_cur.count, drv_cur.offset, drv_cur.sector,
                       drv_cur.cbyte};
          in_tuser <= drv_cur.cmd;
        end
      end
      in_tvalid <= nv;
    end
  end

  // ---------------- monitor ----------------
  int  mon_gap = 0;
  bit  mon_quiet = 0;

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    sd_res_t e;
    logic nr;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        activity++;
        if (expected.size() == 0) begin
          $error("result transfer with nothing expected: kind %0d data 0x%0h",
                 out_tuser, out_tdata);
          fails++;
        end else begin
          e = expected.pop_front();
          check_field("kind", e.kind, out_tuser);
          check_field("tx_byte", e.tx, out_tdata[7:0]);
          check_field("chip_select", e.cs, out_tdata[8]);
          check_field("read_byte", e.rd, out_tdata[16:9]);
          check_field("status", e.st, out_tdata[18:17]);
          check_field("delay_ms", e.dly, out_tdata[22:19]);
          check_field("fast_clock", e.fast, out_tdata[23]);
          check_field("last", e.last, out_tlast);
        end
      end
      if ($urandom_range(0, 399) == 0) mon_quiet = !mon_quiet;
      if (mon_gap > 0) begin
        mon_gap--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
        mon_gap = pick_gap(mon_quiet);
      end
      out_tready <= nr;
    end
  end

  // watchdog: give up when nothing moves for too long
  int stuck = 0;
  int seen = 0;
  always @(posedge clk) begin
    if (activity != seen || cfg_wen || !rst_n) begin
      seen = activity;
      stuck = 0;
    end else if (++stuck >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------- sequence of phases ----------------
  initial begin
    sd_req_t r;
    plan_st = reset_state();
    pred_st = reset_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: stray events, lone write byte, init, short writes, refused request
    phase_items = 0;
    queue_req(rand_req(REQ_CARD_BYTE));
    queue_req(rand_req(REQ_DELAY_DONE));
    queue_req(rand_req(REQ_UNUSED));
    do_request(rand_req(REQ_WR_BYTE));
    do_request(rand_req(REQ_INIT));
    do_write(3, 1);
    do_write(2, 0);
    do_write(0, 1);       // start on an open block abandons it
    queue_req(rand_req(REQ_WR_START));
    r = rand_req(REQ_READ);
    queue_req(r);         // refused while busy
    play_card();

    // tight limits keep reads and failing inits short
    set_limits(8'd2, 8'd3, 16'd3, 16'd4, 16'd3);
    do_read(32'hFFFF_FFFF, 9'd511, 10'd512);
    dead_card = 1;
    do_request(rand_req(REQ_INIT));
    dead_card = 0;
    random_traffic(40);

    // zero limits behave as one
    set_limits(8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
    random_traffic(20);

    wait_quiet();
    if (fails == 0 && expected.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
